>>> src/tcf_pkg.sv
// Shared types and constants for the telnet command filter with receive FIFO.
// Used by tcf_front, tcf_queue, tcf_back and the top level.
package tcf_pkg;

   // Request opcodes
   localparam logic [1:0] OPC_RECEIVE = 2'd0;
   localparam logic [1:0] OPC_READ    = 2'd1;
   localparam logic [1:0] OPC_DROP    = 2'd2;

   // Telnet protocol bytes
   localparam logic [7:0] CODE_IAC = 8'd255;
   localparam logic [7:0] CODE_SB  = 8'd250;
   localparam logic [7:0] CODE_SE  = 8'd240;

   // Fate codes reported with each response word
   localparam logic [1:0] FATE_STORED  = 2'd0;
   localparam logic [1:0] FATE_DROPPED = 2'd1;
   localparam logic [1:0] FATE_COMMAND = 2'd2;
   localparam logic [1:0] FATE_NONE    = 2'd3;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      FLT_IDLE = 2'd0,
      FLT_CMD  = 2'd1,
      FLT_OPT  = 2'd2
   } filter_state_type;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_READ = 2'd1,
      OP_CMD  = 2'd2,
      OP_NONE = 2'd3
   } op_kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_READ = 1'b1
   } back_state_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
   } queue_entry_type;

endpackage

>>> src/tcf_front.sv
// Front end: accepts request words, runs the telnet command filter and
// classifies each word for the back end. Depends on tcf_pkg.
module tcf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_opcode,
   input  logic [7:0]               req_net_byte,
   input  logic                     q_full,
   output logic                     q_push,
   output tcf_pkg::queue_entry_type q_entry
);
   import tcf_pkg::*;

   filter_state_type filter_state_ff;
   filter_state_type filter_state_in;
   logic             accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   // Advance the filter on accepted receive words, clear it on disconnect
   always_comb begin
      filter_state_in = filter_state_ff;
      if (accept) begin
         unique case (req_opcode)
            OPC_RECEIVE: begin
               unique case (filter_state_ff)
                  FLT_CMD: begin
                     filter_state_in = (req_net_byte >= CODE_SB && req_net_byte != CODE_SE)
                                       ? FLT_OPT : FLT_IDLE;
                  end
                  FLT_OPT: begin
                     filter_state_in = FLT_IDLE;
                  end
                  default: begin
                     filter_state_in = (req_net_byte == CODE_IAC) ? FLT_CMD : FLT_IDLE;
                  end
               endcase
            end
            OPC_DROP: begin
               filter_state_in = FLT_IDLE;
            end
            default: begin
               filter_state_in = filter_state_ff;
            end
         endcase
      end
   end

   // Classify the word for the back end
   always_comb begin
      q_entry.data = req_net_byte;
      unique case (req_opcode)
         OPC_RECEIVE: begin
            if (filter_state_ff == FLT_CMD || filter_state_ff == FLT_OPT ||
                req_net_byte == CODE_IAC) begin
               q_entry.kind = OP_CMD;
            end else begin
               q_entry.kind = OP_PUSH;
            end
         end
         OPC_READ: begin
            q_entry.kind = OP_READ;
         end
         default: begin
            q_entry.kind = OP_NONE;
         end
      endcase
   end

   // Hold filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_state_ff <= FLT_IDLE;
      end else begin
         filter_state_ff <= filter_state_in;
      end
   end

endmodule

>>> src/tcf_queue.sv
// Short queue of classified words between the front and back ends.
// Depends on tcf_pkg.
module tcf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tcf_pkg::queue_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output tcf_pkg::queue_entry_type head_entry
);
   import tcf_pkg::*;

   localparam logic [QUEUE_IW-1:0] LAST_IDX = QUEUE_IW'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CW-1:0] FULL_CNT = QUEUE_CW'(QUEUE_DEPTH);

   queue_entry_type       entries_ff [QUEUE_DEPTH];
   logic [QUEUE_IW-1:0]   wr_idx_ff;
   logic [QUEUE_IW-1:0]   rd_idx_ff;
   logic [QUEUE_CW-1:0]   count_ff;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_idx_ff];

   // Store pushed words
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_idx_ff] <= push_entry;
      end
   end

   // Advance indexes and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_idx_ff <= (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
         end
         if (pop) begin
            rd_idx_ff <= (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

>>> src/tcf_back.sv
// Back end: carries out pushes and pops on the receive store and drives the
// registered response word. Depends on tcf_pkg.
module tcf_back #(
   parameter int RX_DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  tcf_pkg::queue_entry_type q_entry,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_read_byte,
   output logic                     rsp_fifo_empty,
   output logic [1:0]               rsp_byte_fate
);
   import tcf_pkg::*;

   localparam int            AW        = $clog2(RX_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(RX_DEPTH - 1);

   logic [7:0]     store_mem [RX_DEPTH];
   logic [7:0]     mem_rd_ff;
   logic [AW-1:0]  wr_addr_ff;
   logic [AW-1:0]  rd_addr_ff;
   logic           wr_wrap_ff;
   logic           rd_wrap_ff;
   back_state_type back_state_ff;
   back_state_type back_state_in;
   logic           rsp_valid_ff;
   logic [7:0]     rsp_read_byte_ff;
   logic           rsp_fifo_empty_ff;
   logic [1:0]     rsp_byte_fate_ff;

   logic           fifo_empty;
   logic           fifo_full;
   logic           out_free;
   logic           take;
   logic           push_store;
   logic           rd_issue;
   logic           load_valid;
   logic [7:0]     load_byte;
   logic           load_empty;
   logic [1:0]     load_fate;

   assign fifo_empty = (wr_addr_ff == rd_addr_ff) && (wr_wrap_ff == rd_wrap_ff);
   assign fifo_full  = (wr_addr_ff == rd_addr_ff) && (wr_wrap_ff != rd_wrap_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign take       = q_valid && (back_state_ff == BK_IDLE) && out_free;
   assign q_pop      = take;
   assign push_store = take && (q_entry.kind == OP_PUSH) && !fifo_full;
   assign rd_issue   = take && (q_entry.kind == OP_READ) && !fifo_empty;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_read_byte_ff;
   assign rsp_fifo_empty = rsp_fifo_empty_ff;
   assign rsp_byte_fate  = rsp_byte_fate_ff;

   // Next state: after a store read, wait in BK_READ for the read data
   always_comb begin
      unique case (back_state_ff)
         BK_IDLE: back_state_in = rd_issue ? BK_READ : BK_IDLE;
         BK_READ: back_state_in = BK_IDLE;
         default: back_state_in = BK_IDLE;
      endcase
   end

   // Build the response word to load
   always_comb begin
      load_valid = 1'b0;
      load_byte  = '0;
      load_empty = 1'b0;
      load_fate  = FATE_NONE;
      unique case (back_state_ff)
         BK_READ: begin
            load_valid = 1'b1;
            load_byte  = mem_rd_ff;
         end
         default: begin
            if (take) begin
               unique case (q_entry.kind)
                  OP_PUSH: begin
                     load_valid = 1'b1;
                     load_fate  = fifo_full ? FATE_DROPPED : FATE_STORED;
                  end
                  OP_READ: begin
                     load_valid = fifo_empty;
                     load_empty = fifo_empty;
                  end
                  OP_CMD: begin
                     load_valid = 1'b1;
                     load_fate  = FATE_COMMAND;
                  end
                  default: begin
                     load_valid = 1'b1;
                  end
               endcase
            end
         end
      endcase
   end

   // Write the receive store
   always_ff @(posedge clock) begin
      if (push_store) begin
         store_mem[wr_addr_ff] <= q_entry.data;
      end
   end

   // Read the receive store
   always_ff @(posedge clock) begin
      if (rd_issue) begin
         mem_rd_ff <= store_mem[rd_addr_ff];
      end
   end

   // Advance pointers and state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_addr_ff    <= '0;
         wr_wrap_ff    <= 1'b0;
         rd_addr_ff    <= '0;
         rd_wrap_ff    <= 1'b0;
         back_state_ff <= BK_IDLE;
      end else begin
         back_state_ff <= back_state_in;
         if (push_store) begin
            if (wr_addr_ff == LAST_ADDR) begin
               wr_addr_ff <= '0;
               wr_wrap_ff <= !wr_wrap_ff;
            end else begin
               wr_addr_ff <= wr_addr_ff + 1'b1;
            end
         end
         if (rd_issue) begin
            if (rd_addr_ff == LAST_ADDR) begin
               rd_addr_ff <= '0;
               rd_wrap_ff <= !rd_wrap_ff;
            end else begin
               rd_addr_ff <= rd_addr_ff + 1'b1;
            end
         end
      end
   end

   // Hold the response word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid) begin
         rsp_read_byte_ff  <= load_byte;
         rsp_fifo_empty_ff <= load_empty;
         rsp_byte_fate_ff  <= load_fate;
      end
   end

   // A pending store read always finds the response register free
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      back_state_ff == BK_READ |-> !rsp_valid_ff)
      else $error("response register busy while store read pending");

   // Store read data shows as a non-empty response in the next cycle
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      back_state_ff == BK_READ |=> rsp_valid_ff && !rsp_fifo_empty)
      else $error("store read did not produce a response word");

   // Write pointer moves only on a stored byte
   a_wr_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      !push_store |=> $stable({wr_wrap_ff, wr_addr_ff}))
      else $error("write pointer moved without a store");

   // Read pointer moves only on a successful pop
   a_rd_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      !rd_issue |=> $stable({rd_wrap_ff, rd_addr_ff}))
      else $error("read pointer moved without a pop");

endmodule

>>> src/telnet_command_filter_rx_fifo_top.sv
// A word accepted by the front is registered in the queue and then in the response register
// before it shows on rsp_valid; a read that pops a byte also passes the store read port.
// Throughput: one word per cycle while the response side is not stalled, except that a
// successful read holds the back end in BK_READ; a two-word queue lets the front keep accepting meanwhile.
// Reset clears the filter, the queue, the FIFO pointers and the response register;
// receive store contents are not cleared and are only read after being written.
module telnet_command_filter_rx_fifo_top #(
   parameter int RX_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_net_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_fifo_empty,
   output logic [1:0] rsp_byte_fate
);
   import tcf_pkg::*;

   logic            q_full;
   logic            q_push;
   queue_entry_type q_push_entry;
   logic            q_pop;
   logic            q_valid;
   queue_entry_type q_head_entry;

   // Classify incoming words
   tcf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_net_byte (req_net_byte),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (q_push_entry)
   );

   // Decouple front from back
   tcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head_entry)
   );

   // Execute pushes and pops
   tcf_back #(
      .RX_DEPTH (RX_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_entry        (q_head_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_fifo_empty (rsp_fifo_empty),
      .rsp_byte_fate  (rsp_byte_fate)
   );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for telnet_command_filter_rx_fifo_top: a directed word table, then phased random
// traffic (fill, drain, mixed); each response is checked against its typed table row or a
// filter and FIFO predictor. Depends on tcf_pkg and the RTL of the top level.
module tb_top;
   import tcf_pkg::*;

   localparam int         DEPTH        = 256;
   localparam int         PTR_W        = $clog2(DEPTH) + 1;
   localparam logic [1:0] OPC_UNUSED   = 2'd3;
   localparam int         RANDOM_WORDS = 1750;
   localparam int         HOLD_CYCLES  = 80;
   localparam int         SETTLE_CYCLES = 12;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         REPORT_MAX   = 10;
   localparam int         DIRECTED_N   = 25;

   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} traffic_phase_type;
   typedef enum int {SM_OPEN, SM_HALF, SM_HEAVY, SM_LIGHT} stall_mode_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       fifo_empty;
      logic [1:0] fate;
   } console_result_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] b;
   } net_word_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] b;
      logic       typed;
      logic [7:0] rd;
      logic       empty;
      logic [1:0] fate;
   } directed_row_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic [1:0] req_opcode     = 2'd0;
   logic [7:0] req_net_byte   = 8'd0;
   logic       rsp_stall      = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_read_byte;
   logic       rsp_fifo_empty;
   logic [1:0] rsp_byte_fate;

   // Predictor state: filter, FIFO storage and pointers
   filter_state_type  shadow_flt = FLT_IDLE;
   logic [7:0]        shadow_store [DEPTH];
   logic [PTR_W-1:0]  shadow_wr = '0;
   logic [PTR_W-1:0]  shadow_rd = '0;

   console_result_type pending_results [$];
   net_word_type       traffic_q [$];
   int                 fail_count   = 0;
   int                 cycle_count  = 0;
   bit                 hold_off_req = 1'b0;

   telnet_command_filter_rx_fifo_top #(
      .RX_DEPTH(DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_net_byte   (req_net_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_fifo_empty (rsp_fifo_empty),
      .rsp_byte_fate  (rsp_byte_fate)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Advance the filter and FIFO by one word and return its response
   function automatic console_result_type predict_console_word(input logic [1:0] op,
                                                               input logic [7:0] b);
      console_result_type r;
      logic [PTR_W-1:0]   fill;
      r = '{read_byte: 8'd0, fifo_empty: 1'b0, fate: FATE_NONE};
      fill = shadow_wr - shadow_rd;
      case (op)
         OPC_RECEIVE: begin
            r.fate = FATE_COMMAND;
            if (shadow_flt == FLT_CMD) begin
               if (b >= CODE_SB && b != CODE_SE) shadow_flt = FLT_OPT;
               else shadow_flt = FLT_IDLE;
            end else if (shadow_flt == FLT_OPT) begin
               shadow_flt = FLT_IDLE;
            end else if (b == CODE_IAC) begin
               shadow_flt = FLT_CMD;
            end else if (fill >= DEPTH) begin
               r.fate = FATE_DROPPED;
            end else begin
               shadow_store[shadow_wr[PTR_W-2:0]] = b;
               shadow_wr = shadow_wr + 1'b1;
               r.fate = FATE_STORED;
            end
         end
         OPC_READ: begin
            if (fill == 0) begin
               r.fifo_empty = 1'b1;
            end else begin
               r.read_byte = shadow_store[shadow_rd[PTR_W-2:0]];
               shadow_rd = shadow_rd + 1'b1;
            end
         end
         OPC_DROP: shadow_flt = FLT_IDLE;
         default: ;
      endcase
      return r;
   endfunction

   // Offer one word, hold it until accepted, then record its expected response
   task automatic send_word(input logic [1:0] op, input logic [7:0] b, input logic typed,
                            input console_result_type typed_result);
      console_result_type predicted;
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_net_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_console_word(op, b);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // Keep the sender quiet until every expected response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic void push_word(input logic [1:0] op, input logic [7:0] b);
      net_word_type w;
      w.op = op;
      w.b  = b;
      traffic_q.push_back(w);
   endfunction

   function automatic traffic_phase_type phase_at(input int n);
      if (n < 400 || (n >= 1050 && n < 1450)) return PH_FILL;
      if (n < 700 || n >= 1450) return PH_DRAIN;
      return PH_MIXED;
   endfunction

   // Queue the next short sequence: a command, a data byte, a read, a disconnect or noise
   function automatic void queue_traffic(input traffic_phase_type phase);
      int         pick;
      int         cmd_cut;
      int         data_cut;
      int         read_cut;
      int         drop_cut;
      logic [7:0] verb;
      pick = $urandom_range(0, 99);
      case (phase)
         PH_FILL: begin
            cmd_cut = 10; data_cut = 88; read_cut = 94; drop_cut = 97;
         end
         PH_DRAIN: begin
            cmd_cut = 4; data_cut = 18; read_cut = 92; drop_cut = 96;
         end
         default: begin
            cmd_cut = 15; data_cut = 50; read_cut = 88; drop_cut = 94;
         end
      endcase
      if (pick < cmd_cut) begin
         push_word(OPC_RECEIVE, CODE_IAC);
         if ($urandom_range(0, 9) == 0) begin
            // connection lost in the middle of a command
            push_word(OPC_DROP, 8'($urandom));
         end else begin
            if ($urandom_range(0, 3) == 0) verb = 8'($urandom);
            else verb = 8'($urandom_range(240, 255));
            push_word(OPC_RECEIVE, verb);
            if (verb >= CODE_SB) push_word(OPC_RECEIVE, 8'($urandom));
         end
      end else if (pick < data_cut) begin
         push_word(OPC_RECEIVE, 8'($urandom));
      end else if (pick < read_cut) begin
         push_word(OPC_READ, 8'($urandom));
      end else if (pick < drop_cut) begin
         push_word(OPC_DROP, 8'($urandom));
      end else begin
         push_word(OPC_UNUSED, 8'($urandom));
      end
   endfunction

   // Compare each accepted response word with the oldest expectation
   always @(posedge clock) begin : response_check
      console_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("unexpected response word: byte %02h empty %0d fate %0d",
                        rsp_read_byte, rsp_fifo_empty, rsp_byte_fate);
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_byte !== want.read_byte || rsp_fifo_empty !== want.fifo_empty ||
                rsp_byte_fate !== want.fate) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("mismatch: expected %02h/%0d/%0d, actual %02h/%0d/%0d",
                           want.read_byte, want.fifo_empty, want.fate,
                           rsp_read_byte, rsp_fifo_empty, rsp_byte_fate);
            end
         end
      end
   end

   // Stall the response side in stretches of random character, with one long hold-off
   initial begin : rsp_pacer
      int             span;
      stall_mode_type mode;
      bit             hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            span = $urandom_range(1, 24);
            mode = stall_mode_type'($urandom_range(0, 3));
            repeat (span) begin
               case (mode)
                  SM_OPEN:  rsp_stall <= 1'b0;
                  SM_HALF:  rsp_stall <= ($urandom_range(0, 1) == 1);
                  SM_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default:  rsp_stall <= ($urandom_range(0, 7) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      directed_row_type   rows [DIRECTED_N];
      console_result_type typed_result;
      net_word_type       w;
      traffic_phase_type  phase;
      traffic_phase_type  last_phase;
      int                 sent;
      int                 burst_left;
      int                 steady_left;
      int                 gap;

      // op, byte, typed, read_byte, fifo_empty, fate
      rows = '{
         '{OPC_READ,    8'h00,    1'b1, 8'h00, 1'b1, FATE_NONE},    // read right after reset
         '{OPC_UNUSED,  8'hFF,    1'b1, 8'h00, 1'b0, FATE_NONE},
         '{OPC_DROP,    8'hFF,    1'b1, 8'h00, 1'b0, FATE_NONE},
         '{OPC_RECEIVE, 8'h00,    1'b1, 8'h00, 1'b0, FATE_STORED},
         '{OPC_RECEIVE, 8'hFE,    1'b1, 8'h00, 1'b0, FATE_STORED},
         '{OPC_RECEIVE, CODE_IAC, 1'b1, 8'h00, 1'b0, FATE_COMMAND}, // IAC SE ends at once
         '{OPC_RECEIVE, CODE_SE,  1'b1, 8'h00, 1'b0, FATE_COMMAND},
         '{OPC_RECEIVE, CODE_IAC, 1'b1, 8'h00, 1'b0, FATE_COMMAND}, // IAC SB takes an option
         '{OPC_RECEIVE, CODE_SB,  1'b1, 8'h00, 1'b0, FATE_COMMAND},
         '{OPC_RECEIVE, 8'h01,    1'b1, 8'h00, 1'b0, FATE_COMMAND},
         '{OPC_RECEIVE, CODE_IAC, 1'b1, 8'h00, 1'b0, FATE_COMMAND}, // disconnect mid-command
         '{OPC_RECEIVE, 8'hFB,    1'b1, 8'h00, 1'b0, FATE_COMMAND},
         '{OPC_DROP,    8'h00,    1'b1, 8'h00, 1'b0, FATE_NONE},
         '{OPC_RECEIVE, 8'h55,    1'b1, 8'h00, 1'b0, FATE_STORED},
         '{OPC_RECEIVE, CODE_IAC, 1'b1, 8'h00, 1'b0, FATE_COMMAND}, // doubled IAC
         '{OPC_RECEIVE, CODE_IAC, 1'b1, 8'h00, 1'b0, FATE_COMMAND},
         '{OPC_RECEIVE, 8'hAA,    1'b1, 8'h00, 1'b0, FATE_COMMAND},
         '{OPC_RECEIVE, CODE_IAC, 1'b1, 8'h00, 1'b0, FATE_COMMAND}, // verb just below SB
         '{OPC_RECEIVE, 8'hF9,    1'b1, 8'h00, 1'b0, FATE_COMMAND},
         '{OPC_RECEIVE, 8'h80,    1'b0, 8'h00, 1'b0, FATE_NONE},
         '{OPC_READ,    8'hFF,    1'b0, 8'h00, 1'b0, FATE_NONE},
         '{OPC_READ,    8'h00,    1'b0, 8'h00, 1'b0, FATE_NONE},
         '{OPC_READ,    8'h00,    1'b0, 8'h00, 1'b0, FATE_NONE},
         '{OPC_READ,    8'h00,    1'b0, 8'h00, 1'b0, FATE_NONE},
         '{OPC_READ,    8'h00,    1'b1, 8'h00, 1'b1, FATE_NONE}     // drained again
      };

      while (reset) @(posedge clock);

      // Walk the directed table back to back
      foreach (rows[i]) begin
         typed_result = '{read_byte: rows[i].rd, fifo_empty: rows[i].empty,
                          fate: rows[i].fate};
         send_word(rows[i].op, rows[i].b, rows[i].typed, typed_result);
      end
      drain_responses();

      // Random traffic in phases; pause at each phase change until all responses are in
      sent        = 0;
      burst_left  = $urandom_range(1, 30);
      steady_left = 0;
      last_phase  = PH_FILL;
      while (sent < RANDOM_WORDS) begin
         phase = phase_at(sent);
         if (phase != last_phase) begin
            drain_responses();
            last_phase = phase;
         end
         if (traffic_q.size() == 0) queue_traffic(phase);
         w = traffic_q.pop_front();
         // hold the receiver off while the sender keeps pushing, to back up the block
         if (sent == 100 && steady_left == 0) begin
            hold_off_req = 1'b1;
            steady_left  = 60;
         end
         send_word(w.op, w.b, 1'b0, '0);
         if (w.op != OPC_UNUSED) sent++;
         // pace the sender in bursts, no gaps during the hold-off
         if (steady_left > 0) begin
            steady_left--;
         end else begin
            burst_left--;
            if (burst_left <= 0) begin
               gap = $urandom_range(0, 6);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 30);
            end
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
src/tcf_pkg.sv
src/tcf_front.sv
src/tcf_queue.sv
src/tcf_back.sv
src/telnet_command_filter_rx_fifo_top.sv
tb/sv/tb_top.sv
